[hw/rtl/spq_pkg.sv]
// Shared types and codes for the sorted priority queue.
package spq_pkg;

   // Operation carried by each request item.
   typedef enum logic [1:0] {
      OP_ENQUEUE  = 2'd0,
      OP_DEQUEUE  = 2'd1,
      OP_DEQ_EXACT = 2'd2,
      OP_DEQ_LIMIT = 2'd3
   } op_type;

   // Response status codes.
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT
   } state_type;

   // What every cell does in a cycle.
   typedef enum logic [1:0] {
      ACT_HOLD,
      ACT_INSERT,
      ACT_SHIFT_ALL,
      ACT_SHIFT_GE
   } act_type;

   typedef struct packed {
      act_type act;
   } cell_ctl_type;

   // Comparison of a cell's entry against the broadcast key.
   typedef struct packed {
      logic gt;   // valid and priority above key
      logic le;   // valid and priority at or below key
      logic eq;   // valid and priority equal to key
   } cell_cmp_type;

endpackage

[hw/rtl/spq_req_if.sv]
// Request channel interface of the sorted priority queue.
interface spq_req_if #(
   parameter int PRIORITY_BITS = 8,
   parameter int DATA_BITS     = 16
);
   logic                     valid;
   logic                     ready;
   logic [1:0]               opcode;
   logic [PRIORITY_BITS-1:0] key;
   logic [PRIORITY_BITS-1:0] limit;
   logic [DATA_BITS-1:0]     payload;

   modport source (output valid, output opcode, output key, output limit, output payload,
                   input ready);
   modport sink   (input valid, input opcode, input key, input limit, input payload,
                   output ready);
endinterface

[hw/rtl/spq_rsp_if.sv]
// Response channel interface of the sorted priority queue.
interface spq_rsp_if #(
   parameter int DATA_BITS = 16,
   parameter int OCC_BITS  = 5
);
   logic                 valid;
   logic                 ready;
   logic [DATA_BITS-1:0] out_payload;
   logic                 found;
   logic [1:0]           status;
   logic [OCC_BITS-1:0]  occupancy;

   modport source (output valid, output out_payload, output found, output status,
                   output occupancy, input ready);
   modport sink   (input valid, input out_payload, input found, input status,
                   input occupancy, output ready);
endinterface

[hw/rtl/spq_cell.sv]
// One slot of the sorted chain: holds an entry and trades it with its neighbours.
module spq_cell import spq_pkg::*; #(
   parameter int PRIORITY_BITS = 8,
   parameter int DATA_BITS     = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctl_type             ctl,
   input  logic [PRIORITY_BITS-1:0] key,
   input  logic [DATA_BITS-1:0]     payload,
   input  logic                     left_valid,
   input  logic [PRIORITY_BITS-1:0] left_prio,
   input  logic [DATA_BITS-1:0]     left_data,
   input  cell_cmp_type             left_cmp,
   input  logic                     right_valid,
   input  logic [PRIORITY_BITS-1:0] right_prio,
   input  logic [DATA_BITS-1:0]     right_data,
   output logic                     valid,
   output logic [PRIORITY_BITS-1:0] prio,
   output logic [DATA_BITS-1:0]     data,
   output cell_cmp_type             cmp
);

   logic                     valid_ff, valid_in;
   logic [PRIORITY_BITS-1:0] prio_ff, prio_in;
   logic [DATA_BITS-1:0]     data_ff, data_in;

   always_comb begin
      cmp.gt = valid_ff && (prio_ff > key);
      cmp.le = valid_ff && (prio_ff <= key);
      cmp.eq = valid_ff && (prio_ff == key);
   end

   always_comb begin
      valid_in = valid_ff;
      prio_in  = prio_ff;
      data_in  = data_ff;
      case (ctl.act)
         ACT_INSERT: begin
            // Entries above the key move one slot right; the first slot past
            // the last entry at or below the key takes the new one.
            if (left_cmp.gt) begin
               valid_in = left_valid;
               prio_in  = left_prio;
               data_in  = left_data;
            end else if (left_cmp.le && !cmp.le) begin
               valid_in = 1'b1;
               prio_in  = key;
               data_in  = payload;
            end
         end
         ACT_SHIFT_ALL: begin
            valid_in = right_valid;
            prio_in  = right_prio;
            data_in  = right_data;
         end
         ACT_SHIFT_GE: begin
            if (!valid_ff || prio_ff >= key) begin
               valid_in = right_valid;
               prio_in  = right_prio;
               data_in  = right_data;
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prio_ff <= prio_in;
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign prio  = prio_ff;
   assign data  = data_ff;

endmodule

[hw/rtl/sorted_priority_queue_core.sv]
// Top level of the sorted priority queue: sequencer, cell chain and response register.
//
//   channel   dir   handshake        payload
//   req_ch    in    valid / ready    opcode, key, limit, payload
//   rsp_ch    out   valid / ready    out_payload, found, status, occupancy
//
// An item is taken only in the idle state. Enqueue, dequeue and threshold
// dequeue then go to the commit state, which loads the response register;
// an exact dequeue first passes the scan state, which gathers the match flags
// of all cells into one registered hit bit and payload before the chain moves.
// The chain updates only when the response register is free, so a stalled
// response holds the next item in the commit state. Synchronous reset
// clears all valid bits, the occupancy count and the sequencer; the stored
// priorities and payloads are not cleared.
module sorted_priority_queue_core import spq_pkg::*; #(
   parameter int DEPTH         = 16,
   parameter int PRIORITY_BITS = 8,
   parameter int DATA_BITS     = 16
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   // Sequencer and the latched command of the item in flight.
   state_type                state_ff, state_in;
   op_type                   op_ff;
   logic [PRIORITY_BITS-1:0] key_ff;
   logic [PRIORITY_BITS-1:0] limit_ff;
   logic [DATA_BITS-1:0]     payload_ff;

   // Result of the exact-match scan.
   logic                     hit_ff, hit_in;
   logic [DATA_BITS-1:0]     match_ff, match_in;

   logic [CNT_BITS-1:0]      count_ff, count_in;

   logic                     rsp_valid_ff;
   logic [DATA_BITS-1:0]     rsp_data_ff, rsp_data_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;

   logic                     accept;
   logic                     commit;
   logic                     hit;
   act_type                  act;
   cell_ctl_type             cell_ctl;

   logic                     cell_valid [DEPTH];
   logic [PRIORITY_BITS-1:0] cell_prio  [DEPTH];
   logic [DATA_BITS-1:0]     cell_data  [DEPTH];
   cell_cmp_type             cell_cmp   [DEPTH];

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;

   // ------------------------------------------------------------------
   // Cell chain. Each cell sees its left and right neighbour; the ends are
   // tied so that the head always admits an insert and the tail shifts in
   // an empty slot.
   // ------------------------------------------------------------------
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                     lv, rv;
      logic [PRIORITY_BITS-1:0] lp, rp;
      logic [DATA_BITS-1:0]     ld, rd;
      cell_cmp_type             lc;

      if (i == 0) begin : g_head
         assign lv = 1'b0;
         assign lp = '0;
         assign ld = '0;
         assign lc = '{gt: 1'b0, le: 1'b1, eq: 1'b0};
      end else begin : g_inner_left
         assign lv = cell_valid[i-1];
         assign lp = cell_prio[i-1];
         assign ld = cell_data[i-1];
         assign lc = cell_cmp[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign rv = 1'b0;
         assign rp = '0;
         assign rd = '0;
      end else begin : g_inner_right
         assign rv = cell_valid[i+1];
         assign rp = cell_prio[i+1];
         assign rd = cell_data[i+1];
      end

      spq_cell #(
         .PRIORITY_BITS (PRIORITY_BITS),
         .DATA_BITS     (DATA_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl),
         .key         (key_ff),
         .payload     (payload_ff),
         .left_valid  (lv),
         .left_prio   (lp),
         .left_data   (ld),
         .left_cmp    (lc),
         .right_valid (rv),
         .right_prio  (rp),
         .right_data  (rd),
         .valid       (cell_valid[i]),
         .prio        (cell_prio[i]),
         .data        (cell_data[i]),
         .cmp         (cell_cmp[i])
      );
   end

   // ------------------------------------------------------------------
   // Exact-match scan. Equal priorities sit side by side, so the oldest
   // match is the matching cell whose left neighbour does not match.
   // ------------------------------------------------------------------
   always_comb begin
      hit_in   = 1'b0;
      match_in = '0;
      for (int j = 0; j < DEPTH; j++) begin
         hit_in = hit_in | cell_cmp[j].eq;
         if (cell_cmp[j].eq && (j == 0 || !cell_cmp[(j == 0) ? 0 : j-1].eq)) begin
            match_in = match_in | cell_data[j];
         end
      end
   end

   // ------------------------------------------------------------------
   // Decision for the commit cycle.
   // ------------------------------------------------------------------
   always_comb begin
      hit           = 1'b0;
      act           = ACT_HOLD;
      rsp_data_in   = '0;
      rsp_found_in  = 1'b0;
      rsp_status_in = ST_MISS;
      count_in      = count_ff;
      case (op_ff)
         OP_ENQUEUE: begin
            hit = (count_ff != CNT_BITS'(DEPTH));
            if (hit) begin
               act           = ACT_INSERT;
               rsp_status_in = ST_OK;
               count_in      = count_ff + 1'b1;
            end else begin
               rsp_status_in = ST_FULL;
            end
         end
         OP_DEQUEUE: begin
            hit = (count_ff != '0);
            act = ACT_SHIFT_ALL;
         end
         OP_DEQ_EXACT: begin
            hit = hit_ff;
            act = ACT_SHIFT_GE;
         end
         OP_DEQ_LIMIT: begin
            hit = (count_ff != '0) && (cell_prio[0] <= limit_ff);
            act = ACT_SHIFT_ALL;
         end
         default: begin
            hit = 1'b0;
         end
      endcase
      if (op_ff != OP_ENQUEUE) begin
         if (hit) begin
            rsp_found_in  = 1'b1;
            rsp_status_in = ST_OK;
            rsp_data_in   = (op_ff == OP_DEQ_EXACT) ? match_ff : cell_data[0];
            count_in      = count_ff - 1'b1;
         end else begin
            act = ACT_HOLD;
         end
      end
   end

   assign commit       = (state_ff == S_COMMIT) && (!rsp_valid_ff || rsp_ch.ready);
   assign cell_ctl.act = commit ? act : ACT_HOLD;

   // ------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = (op_type'(req_ch.opcode) == OP_DEQ_EXACT) ? S_SCAN : S_COMMIT;
            end
         end
         S_SCAN: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= op_type'(req_ch.opcode);
         key_ff     <= req_ch.key;
         limit_ff   <= req_ch.limit;
         payload_ff <= req_ch.payload;
      end
      if (state_ff == S_SCAN) begin
         hit_ff   <= hit_in;
         match_ff <= match_in;
      end
      if (commit) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_payload = rsp_data_ff;
   assign rsp_ch.found       = rsp_found_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.occupancy   = count_ff;

   // ------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("occupancy count beyond queue depth");

   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      cell_valid[0] == (count_ff != '0))
      else $error("head cell valid bit disagrees with occupancy count");

   a_tail_valid: assert property (@(posedge clock) disable iff (reset)
      cell_valid[DEPTH-1] == (count_ff == CNT_BITS'(DEPTH)))
      else $error("tail cell valid bit disagrees with occupancy count");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_found_ff |-> rsp_data_ff == '0)
      else $error("response carries a payload without a removed entry");

   a_commit_count: assert property (@(posedge clock) disable iff (reset)
      commit && rsp_found_in |=> count_ff == $past(count_ff) - 1'b1)
      else $error("removal did not lower the occupancy count");

endmodule

[test/tb_sorted_priority_queue_core.sv]
// Self-checking testbench of the sorted priority queue: directed table, then random traffic.
module tb_sorted_priority_queue_core import spq_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int  DEPTH          = 16;
   localparam int  PRIORITY_BITS  = 8;
   localparam int  DATA_BITS      = 16;
   localparam int  OCC_BITS       = 5;
   localparam time CLOCK_PERIOD   = 4ns;
   localparam int  RESET_CYCLES   = 7;
   localparam int  RANDOM_ITEMS   = 400;
   localparam int  MOOD_LENGTH    = 40;
   localparam int  SETTLE_CYCLES  = 12;
   localparam int  CYCLE_LIMIT    = 200000;
   localparam int  PRINT_LIMIT    = 40;

   // One request item as the sender sees it.
   typedef struct packed {
      op_type                   op;
      logic [PRIORITY_BITS-1:0] key;
      logic [PRIORITY_BITS-1:0] limit;
      logic [DATA_BITS-1:0]     payload;
   } request_type;

   // One response item: removed payload, hit flag, status code and fill level.
   typedef struct packed {
      logic [DATA_BITS-1:0] data;
      logic                 found;
      logic [1:0]           status;
      logic [OCC_BITS-1:0]  occ;
   } outcome_type;

   // A row of the directed table. Where typed is set, the outcome in the row is
   // the one checked; otherwise the predictor supplies it.
   typedef struct packed {
      request_type rq;
      logic        typed;
      outcome_type want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   spq_req_if #(.PRIORITY_BITS(PRIORITY_BITS), .DATA_BITS(DATA_BITS)) req_bus ();
   spq_rsp_if #(.DATA_BITS(DATA_BITS), .OCC_BITS(OCC_BITS))           rsp_bus ();

   sorted_priority_queue_core #(
      .DEPTH        (DEPTH),
      .PRIORITY_BITS(PRIORITY_BITS),
      .DATA_BITS    (DATA_BITS)
   ) uut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_bus.sink),
      .rsp_ch(rsp_bus.source)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Shadow copy of the queue contents, kept in ascending priority order with
   // ties in arrival order, exactly as the block is meant to hold them.
   logic [PRIORITY_BITS-1:0] shadow_prio [DEPTH];
   logic [DATA_BITS-1:0]     shadow_data [DEPTH];
   int                       shadow_count = 0;

   outcome_type   awaited_outcomes [$];
   table_row_type directed_rows [$];

   int  mismatches      = 0;
   int  cycle_count     = 0;
   int  accepted_items  = 0;
   int  checked_items   = 0;
   int  drops_when_full = 0;
   int  removals        = 0;
   int  misses          = 0;
   int  times_full      = 0;
   int  times_emptied   = 0;
   bit  calm_phase      = 1'b0;

   // Works out the response to one accepted item and updates the shadow queue.
   function automatic outcome_type apply_queue_op(request_type rq);
      outcome_type res;
      int          pos;
      int          hit;
      int          i;
      res        = '0;
      res.status = ST_MISS;
      hit        = -1;
      case (rq.op)
         OP_ENQUEUE: begin
            if (shadow_count >= DEPTH) begin
               res.status = ST_FULL;
               drops_when_full++;
            end else begin
               // Equal priorities go behind the ones already held.
               pos = 0;
               while (pos < shadow_count && shadow_prio[pos] <= rq.key)
                  pos++;
               for (i = shadow_count; i > pos; i--) begin
                  shadow_prio[i] = shadow_prio[i-1];
                  shadow_data[i] = shadow_data[i-1];
               end
               shadow_prio[pos] = rq.key;
               shadow_data[pos] = rq.payload;
               shadow_count++;
               res.status = ST_OK;
               if (shadow_count == DEPTH)
                  times_full++;
            end
         end
         OP_DEQUEUE: begin
            if (shadow_count > 0)
               hit = 0;
         end
         OP_DEQ_EXACT: begin
            // The oldest entry of that priority is the first one found.
            for (i = 0; i < shadow_count; i++)
               if (hit < 0 && shadow_prio[i] == rq.key)
                  hit = i;
         end
         default: begin
            if (shadow_count > 0 && shadow_prio[0] <= rq.limit)
               hit = 0;
         end
      endcase
      if (hit >= 0) begin
         res.data   = shadow_data[hit];
         res.found  = 1'b1;
         res.status = ST_OK;
         for (i = hit; i < shadow_count - 1; i++) begin
            shadow_prio[i] = shadow_prio[i+1];
            shadow_data[i] = shadow_data[i+1];
         end
         shadow_count--;
         removals++;
         if (shadow_count == 0)
            times_emptied++;
      end else if (rq.op != OP_ENQUEUE) begin
         misses++;
      end
      res.occ = OCC_BITS'(shadow_count);
      return res;
   endfunction

   // Length of the next pause on either side: mostly none or short, now and
   // then a long one, and none at all while a calm phase runs.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm_phase)
         return 0;
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Prints one line per mismatch, up to a cap, and counts every one.
   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s, got %0h, expected %0h",
                  cycle_count, what, got, want);
   endtask

   task automatic add_row(op_type op, logic [PRIORITY_BITS-1:0] key,
                          logic [PRIORITY_BITS-1:0] limit, logic [DATA_BITS-1:0] payload,
                          logic typed, logic [1:0] status, logic [OCC_BITS-1:0] occ);
      table_row_type row;
      row.rq.op      = op;
      row.rq.key     = key;
      row.rq.limit   = limit;
      row.rq.payload = payload;
      row.typed      = typed;
      // Typed rows never remove anything, so the payload and hit flag are zero.
      row.want       = {{DATA_BITS{1'b0}}, 1'b0, status, occ};
      directed_rows.push_back(row);
   endtask

   // Offers one item, waits for it to be taken, then records its expectation.
   // Called at a rising edge; valid gets at most one assignment per time step.
   task automatic send_request(request_type rq, logic typed, outcome_type want);
      outcome_type predicted;
      int          gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.opcode  <= rq.op;
      req_bus.key     <= rq.key;
      req_bus.limit   <= rq.limit;
      req_bus.payload <= rq.payload;
      do
         @(posedge clock);
      while (req_bus.ready !== 1'b1);
      predicted = apply_queue_op(rq);
      awaited_outcomes.push_back(typed ? want : predicted);
      accepted_items++;
   endtask

   // Random item shaped by the current mood: enq_pct sets how hard the queue
   // is pushed towards full or empty. Exact dequeues mostly name a priority
   // that is held, and threshold dequeues often sit near the head priority.
   function automatic request_type make_random_request(int enq_pct);
      request_type rq;
      int          r;
      r          = $urandom_range(0, 99);
      rq.payload = DATA_BITS'($urandom());
      rq.limit   = PRIORITY_BITS'($urandom());
      if ($urandom_range(0, 3) == 0)
         rq.key = PRIORITY_BITS'($urandom());
      else
         rq.key = PRIORITY_BITS'($urandom_range(0, 15));
      if (r < enq_pct) begin
         rq.op = OP_ENQUEUE;
      end else begin
         case ($urandom_range(0, 2))
            0:       rq.op = OP_DEQUEUE;
            1:       rq.op = OP_DEQ_EXACT;
            default: rq.op = OP_DEQ_LIMIT;
         endcase
      end
      if (rq.op == OP_DEQ_EXACT && shadow_count > 0 && $urandom_range(0, 9) < 7)
         rq.key = shadow_prio[$urandom_range(0, shadow_count - 1)];
      if (rq.op == OP_DEQ_LIMIT && shadow_count > 0 && $urandom_range(0, 1) == 0)
         rq.limit = shadow_prio[0] + PRIORITY_BITS'($urandom_range(0, 2)) - 8'd1;
      return rq;
   endfunction

   // Response side: checks every item taken at a rising edge against the
   // oldest expectation, then decides whether ready is held low next cycle.
   initial begin : response_side
      outcome_type want;
      int          stall_left;
      stall_left   = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (awaited_outcomes.size() == 0) begin
               report_mismatch("response with nothing outstanding",
                               32'({rsp_bus.out_payload, rsp_bus.found, rsp_bus.status,
                                    rsp_bus.occupancy}), 32'h0);
            end else begin
               want = awaited_outcomes.pop_front();
               checked_items++;
               if (rsp_bus.out_payload !== want.data)
                  report_mismatch("out_payload", 32'(rsp_bus.out_payload), 32'(want.data));
               if (rsp_bus.found !== want.found)
                  report_mismatch("found", 32'(rsp_bus.found), 32'(want.found));
               if (rsp_bus.status !== want.status)
                  report_mismatch("status", 32'(rsp_bus.status), 32'(want.status));
               if (rsp_bus.occupancy !== want.occ)
                  report_mismatch("occupancy", 32'(rsp_bus.occupancy), 32'(want.occ));
            end
         end
         if (stall_left > 0)
            stall_left--;
         else
            stall_left = pick_gap();
         rsp_bus.ready <= (stall_left == 0);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[sorted_priority_queue_core] ERROR");
         $finish;
      end
   end

   initial begin : request_side
      request_type rq;
      int          enq_pct;
      int          n;
      req_bus.valid   <= 1'b0;
      req_bus.opcode  <= OP_ENQUEUE;
      req_bus.key     <= '0;
      req_bus.limit   <= '0;
      req_bus.payload <= '0;
      enq_pct         = 50;

      // Directed table. It opens on the empty queue with all three kinds of
      // removal, fills the queue with extreme and repeated priorities, tries
      // one enqueue too many, and then removes by threshold, by exact match, with
      // a missing priority, with the head above the threshold, and by plain dequeue.
      add_row(OP_DEQUEUE,   8'd0,   8'd0,   16'h0000, 1'b1, ST_MISS, 5'd0);
      add_row(OP_DEQ_EXACT, 8'd0,   8'd0,   16'hffff, 1'b1, ST_MISS, 5'd0);
      add_row(OP_DEQ_LIMIT, 8'd255, 8'd255, 16'hffff, 1'b1, ST_MISS, 5'd0);
      add_row(OP_ENQUEUE,   8'd255, 8'd0,   16'hffff, 1'b1, ST_OK,   5'd1);
      add_row(OP_ENQUEUE,   8'd0,   8'd255, 16'h0000, 1'b1, ST_OK,   5'd2);
      add_row(OP_ENQUEUE,   8'd128, 8'd0,   16'haaaa, 1'b1, ST_OK,   5'd3);
      add_row(OP_ENQUEUE,   8'd1,   8'd0,   16'h5555, 1'b1, ST_OK,   5'd4);
      add_row(OP_ENQUEUE,   8'd255, 8'd0,   16'h1234, 1'b1, ST_OK,   5'd5);
      add_row(OP_ENQUEUE,   8'd1,   8'd0,   16'h8001, 1'b1, ST_OK,   5'd6);
      add_row(OP_ENQUEUE,   8'd254, 8'd0,   16'h7ffe, 1'b1, ST_OK,   5'd7);
      add_row(OP_ENQUEUE,   8'd128, 8'd0,   16'h0f0f, 1'b1, ST_OK,   5'd8);
      add_row(OP_ENQUEUE,   8'd127, 8'd0,   16'hf0f0, 1'b1, ST_OK,   5'd9);
      add_row(OP_ENQUEUE,   8'd2,   8'd0,   16'h0002, 1'b1, ST_OK,   5'd10);
      add_row(OP_ENQUEUE,   8'd64,  8'd0,   16'h4000, 1'b1, ST_OK,   5'd11);
      add_row(OP_ENQUEUE,   8'd200, 8'd0,   16'hc8c8, 1'b1, ST_OK,   5'd12);
      add_row(OP_ENQUEUE,   8'd3,   8'd0,   16'h0303, 1'b1, ST_OK,   5'd13);
      add_row(OP_ENQUEUE,   8'd3,   8'd0,   16'h3030, 1'b1, ST_OK,   5'd14);
      add_row(OP_ENQUEUE,   8'd17,  8'd0,   16'h1717, 1'b1, ST_OK,   5'd15);
      add_row(OP_ENQUEUE,   8'd254, 8'd0,   16'hfefe, 1'b1, ST_OK,   5'd16);
      add_row(OP_ENQUEUE,   8'd5,   8'd0,   16'hdead, 1'b1, ST_FULL, 5'd16);
      add_row(OP_DEQ_LIMIT, 8'd0,   8'd0,   16'h0000, 1'b0, ST_OK,   5'd0);
      add_row(OP_DEQ_EXACT, 8'd255, 8'd0,   16'h0000, 1'b0, ST_OK,   5'd0);
      add_row(OP_DEQ_EXACT, 8'd5,   8'd0,   16'h0000, 1'b1, ST_MISS, 5'd14);
      add_row(OP_DEQ_LIMIT, 8'd0,   8'd0,   16'h0000, 1'b1, ST_MISS, 5'd14);
      add_row(OP_DEQUEUE,   8'd0,   8'd0,   16'h0000, 1'b0, ST_OK,   5'd0);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);

      // Random traffic in phases: each phase leans towards filling, draining
      // or a balance, so the queue swings between full and empty, and some
      // phases run with no pauses on either side.
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % MOOD_LENGTH == 0) begin
            case ($urandom_range(0, 2))
               0:       enq_pct = 80;
               1:       enq_pct = 20;
               default: enq_pct = 50;
            endcase
            calm_phase = ($urandom_range(0, 3) == 0);
         end
         rq = make_random_request(enq_pct);
         send_request(rq, 1'b0, '0);
      end
      req_bus.valid <= 1'b0;
      calm_phase    = 1'b0;

      // Let the last responses drain, then leave room for anything stray.
      while (awaited_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d items (%0d from the table), %0d responses checked",
               accepted_items, directed_rows.size(), checked_items);
      $display("queue filled %0d times and emptied %0d times: %0d removals, %0d misses, %0d drops",
               times_full, times_emptied, removals, misses, drops_when_full);
      if (mismatches == 0)
         $display("[sorted_priority_queue_core] OK");
      else
         $display("[sorted_priority_queue_core] ERROR");
      $finish;
   end

endmodule
